// File: rtl/dtan_pkg.sv
// dtan_pkg: shared widths, constants, reciprocals, command types and calendar helpers
// for the date-time add and normalize unit; depends on nothing
package dtan_pkg;

   localparam int WORK_W   = 40;   // signed working width of all carry sums
   localparam int HALF_W   = WORK_W / 2;   // operand width of the partial products
   localparam int DEN_W    = 30;   // widest divisor (one billion)

   localparam logic [DEN_W-1:0] NS_PER_SEC    = DEN_W'(1000000000);
   localparam logic [DEN_W-1:0] SEC_PER_MIN   = DEN_W'(60);
   localparam logic [DEN_W-1:0] MIN_PER_HOUR  = DEN_W'(60);
   localparam logic [DEN_W-1:0] HOUR_PER_DAY  = DEN_W'(24);
   localparam logic [DEN_W-1:0] YEARS_PER_ERA = DEN_W'(400);
   localparam logic [DEN_W-1:0] DAYS_ERA_DEN  = DEN_W'(146097);
   localparam logic [DEN_W-1:0] DAYS_4Y       = DEN_W'(1460);
   localparam logic [DEN_W-1:0] DAYS_YEAR     = DEN_W'(365);

   // floor(2^WORK_W / divisor), quotient estimate is low by at most one
   localparam logic [63:0]       RCP_ONE  = 64'd1 << WORK_W;
   localparam logic [WORK_W-1:0] RCP_NS   = WORK_W'(RCP_ONE / 64'(NS_PER_SEC));
   localparam logic [WORK_W-1:0] RCP_SEC  = WORK_W'(RCP_ONE / 64'(SEC_PER_MIN));
   localparam logic [WORK_W-1:0] RCP_MIN  = WORK_W'(RCP_ONE / 64'(MIN_PER_HOUR));
   localparam logic [WORK_W-1:0] RCP_HOUR = WORK_W'(RCP_ONE / 64'(HOUR_PER_DAY));
   localparam logic [WORK_W-1:0] RCP_Y400 = WORK_W'(RCP_ONE / 64'(YEARS_PER_ERA));
   localparam logic [WORK_W-1:0] RCP_ERA  = WORK_W'(RCP_ONE / 64'(DAYS_ERA_DEN));
   localparam logic [WORK_W-1:0] RCP_D4Y  = WORK_W'(RCP_ONE / 64'(DAYS_4Y));
   localparam logic [WORK_W-1:0] RCP_YEAR = WORK_W'(RCP_ONE / 64'(DAYS_YEAR));

   localparam logic signed [WORK_W-1:0] DAYS_PER_ERA  = 146097;
   localparam logic signed [WORK_W-1:0] YEARS_ERA_W   = 400;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_MONTH = 2'd1;
   localparam logic [1:0] STATUS_YEAR_OVF  = 2'd2;

   typedef enum logic [2:0] {
      OP_NS    = 3'd0,
      OP_SEC   = 3'd1,
      OP_MIN   = 3'd2,
      OP_HOUR  = 3'd3,
      OP_Y400  = 3'd4,
      OP_ERA   = 3'd5,
      OP_D1460 = 3'd6,
      OP_D365  = 3'd7
   } op_type;

   typedef struct packed {
      logic   load;
      logic   div_start;
      logic   div_apply;
      logic   calc_doy;
      logic   finish;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic bad_month;
      logic div_done;
      logic out_blocked;
   } stat_type;

   // first day-of-year of each month, year counted from march
   function automatic logic [8:0] month_start(input logic [3:0] k);
      logic [8:0] v;
      case (k)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd92;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd184;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd245;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd337;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // year-of-era divided by 100, year-of-era below 400
   function automatic logic [1:0] cent_of(input logic [8:0] yoe);
      return 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
   endfunction

   // day-of-era divided by 36524
   function automatic logic [2:0] cent_days_of(input logic [17:0] doe);
      return 3'(doe >= 18'd36524) + 3'(doe >= 18'd73048) + 3'(doe >= 18'd109572)
           + 3'(doe >= 18'd146096);
   endfunction

endpackage

// File: rtl/dtan_div.sv
// dtan_div: signed floor divider by a constant, reciprocal multiply over four
// partial products, then remainder and one correction step; depends on dtan_pkg
module dtan_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [dtan_pkg::WORK_W-1:0] num,
   input  logic        [dtan_pkg::DEN_W-1:0]  den,
   input  logic        [dtan_pkg::WORK_W-1:0] rcp,
   output logic                              done,
   output logic signed [dtan_pkg::WORK_W-1:0] quot,
   output logic        [dtan_pkg::DEN_W-1:0]  rmd
);
   import dtan_pkg::*;

   localparam logic [2:0] PH_PP_FIRST = 3'd0;
   localparam logic [2:0] PH_PP_LAST  = 3'd3;
   localparam logic [2:0] PH_QUOT     = 3'd4;
   localparam logic [2:0] PH_REM      = 3'd5;
   localparam logic [2:0] PH_FIX      = 3'd6;

   logic [WORK_W-1:0]   mag, mag_ff, mag_in, rcp_ff, rcp_in, q_ff, q_in, prod;
   logic [2*WORK_W-1:0] acc_ff, acc_in, prod_sh;
   logic [HALF_W-1:0]   mul_a, mul_b;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DEN_W:0]      rem_ff, rem_in, qd_low;
   logic [2:0]          ph_ff, ph_in;
   logic                neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      mag   = num[WORK_W-1] ? WORK_W'(-num) : WORK_W'(num);
      // phases 0..3: low*low, low*high, high*low, high*high
      mul_a = ph_ff[1] ? mag_ff[WORK_W-1:HALF_W] : mag_ff[HALF_W-1:0];
      mul_b = ph_ff[0] ? rcp_ff[WORK_W-1:HALF_W] : rcp_ff[HALF_W-1:0];
      prod  = WORK_W'(mul_a) * WORK_W'(mul_b);
      case (ph_ff)
         PH_PP_FIRST: prod_sh = {{WORK_W{1'b0}}, prod};
         PH_PP_LAST:  prod_sh = {prod, {WORK_W{1'b0}}};
         default:     prod_sh = {{HALF_W{1'b0}}, prod, {HALF_W{1'b0}}};
      endcase
      // remainder is below twice the divisor, so low bits suffice
      qd_low  = q_ff[DEN_W:0] * {1'b0, den_ff};
      mag_in  = mag_ff;
      rcp_in  = rcp_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      ph_in   = ph_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = mag;
         rcp_in  = rcp;
         acc_in  = '0;
         den_in  = den;
         neg_in  = num[WORK_W-1];
         ph_in   = PH_PP_FIRST;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         ph_in = ph_ff + 3'd1;
         case (ph_ff)
            PH_QUOT: begin
               q_in = acc_ff[2*WORK_W-1:WORK_W];
            end
            PH_REM: begin
               rem_in = mag_ff[DEN_W:0] - qd_low;
            end
            PH_FIX: begin
               if (rem_ff >= {1'b0, den_ff}) begin
                  q_in   = q_ff + WORK_W'(1);
                  rem_in = rem_ff - {1'b0, den_ff};
               end
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               acc_in = acc_ff + prod_sh;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      rcp_ff <= rcp_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      ph_ff  <= ph_in;
   end

   // floor correction for negative dividends
   always_comb begin
      if (neg_ff && rem_ff != '0) begin
         quot = $signed(~q_ff);
         rmd  = den_ff - rem_ff[DEN_W-1:0];
      end else if (neg_ff) begin
         quot = -$signed(q_ff);
         rmd  = '0;
      end else begin
         quot = $signed(q_ff);
         rmd  = rem_ff[DEN_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

// File: rtl/dtan_dp.sv
// dtan_dp: datapath with carry registers, calendar steps and result register
// depends on dtan_pkg and dtan_div
module dtan_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  dtan_pkg::cmd_type      cmd,
   output dtan_pkg::stat_type     stat,
   input  logic signed [15:0]     req_base_year,
   input  logic signed [7:0]      req_base_month,
   input  logic signed [31:0]     req_base_day,
   input  logic signed [31:0]     req_base_hour,
   input  logic signed [31:0]     req_base_minute,
   input  logic signed [31:0]     req_base_second,
   input  logic signed [31:0]     req_base_nanosecond,
   input  logic signed [31:0]     req_delta_days,
   input  logic signed [31:0]     req_delta_hours,
   input  logic signed [31:0]     req_delta_minutes,
   input  logic signed [31:0]     req_delta_seconds,
   input  logic signed [31:0]     req_delta_nanos,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic signed [15:0]     rsp_out_year,
   output logic [3:0]             rsp_out_month,
   output logic [4:0]             rsp_out_day,
   output logic [4:0]             rsp_out_hour,
   output logic [5:0]             rsp_out_minute,
   output logic [5:0]             rsp_out_second,
   output logic [29:0]            rsp_out_nanosecond,
   output logic [1:0]             rsp_status
);
   import dtan_pkg::*;

   logic signed [WORK_W-1:0] ns_ff, sc_ff, mi_ff, hr_ff, dy_ff, era_ff, era2_ff;
   logic signed [15:0]       yr_ff;
   logic signed [7:0]        mo_ff;
   logic                     bad_ff;
   logic [17:0]              doe_ff, doe2_ff, t_ff;
   logic [8:0]               yoe2_ff, doy_ff;

   logic signed [WORK_W-1:0] div_num, div_quot;
   logic [WORK_W-1:0]        div_rcp;
   logic [DEN_W-1:0]         div_den, div_rmd;
   logic                     div_done;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]       year_ff;
   logic [3:0]               month_ff;
   logic [4:0]               day_ff, hour_ff;
   logic [5:0]               minute_ff, second_ff;
   logic [29:0]              nano_ff;
   logic [1:0]               status_ff;

   logic [3:0]               m_idx, mp, m_out;
   logic [8:0]               yoe;
   logic [17:0]              doe_calc;
   logic signed [WORK_W-1:0] y_out;
   logic [4:0]               d_out;

   dtan_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num    (div_num),
      .den    (div_den),
      .rcp    (div_rcp),
      .done   (div_done),
      .quot   (div_quot),
      .rmd    (div_rmd)
   );

   // dividend, divisor and its reciprocal for each step
   always_comb begin
      case (cmd.op)
         OP_NS: begin
            div_num = ns_ff;
            div_den = NS_PER_SEC;
            div_rcp = RCP_NS;
         end
         OP_SEC: begin
            div_num = sc_ff;
            div_den = SEC_PER_MIN;
            div_rcp = RCP_SEC;
         end
         OP_MIN: begin
            div_num = mi_ff;
            div_den = MIN_PER_HOUR;
            div_rcp = RCP_MIN;
         end
         OP_HOUR: begin
            div_num = hr_ff;
            div_den = HOUR_PER_DAY;
            div_rcp = RCP_HOUR;
         end
         OP_Y400: begin
            div_num = WORK_W'(yr_ff) - ((mo_ff <= 8'sd2) ? WORK_W'(1) : WORK_W'(0));
            div_den = YEARS_PER_ERA;
            div_rcp = RCP_Y400;
         end
         OP_ERA: begin
            div_num = WORK_W'(era_ff * DAYS_PER_ERA) + $signed(WORK_W'(doe_ff))
                    + dy_ff - WORK_W'(1);
            div_den = DAYS_ERA_DEN;
            div_rcp = RCP_ERA;
         end
         OP_D1460: begin
            div_num = $signed(WORK_W'(doe2_ff));
            div_den = DAYS_4Y;
            div_rcp = RCP_D4Y;
         end
         OP_D365: begin
            div_num = $signed(WORK_W'(t_ff));
            div_den = DAYS_YEAR;
            div_rcp = RCP_YEAR;
         end
         default: begin
            div_num = ns_ff;
            div_den = NS_PER_SEC;
            div_rcp = RCP_NS;
         end
      endcase
   end

   // day-of-era of the first of the base month
   always_comb begin
      m_idx    = (mo_ff > 8'sd2) ? 4'(mo_ff - 8'sd3) : 4'(mo_ff + 8'sd9);
      yoe      = div_rmd[8:0];
      doe_calc = 18'(yoe) * 18'd365 + 18'(yoe >> 2) - 18'(cent_of(yoe))
               + 18'(month_start(m_idx));
   end

   // month search over the march-based year
   always_comb begin
      mp = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy_ff >= month_start(4'(k))) mp = 4'(k);
      end
      d_out = 5'(doy_ff - month_start(mp) + 9'd1);
      m_out = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      y_out = WORK_W'(yoe2_ff) + WORK_W'(era2_ff * YEARS_ERA_W)
            + ((m_out <= 4'd2) ? WORK_W'(1) : WORK_W'(0));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         yr_ff  <= req_base_year;
         mo_ff  <= req_base_month;
         bad_ff <= (req_base_month < 8'sd1) || (req_base_month > 8'sd12);
         ns_ff  <= WORK_W'(req_base_nanosecond) + WORK_W'(req_delta_nanos);
         sc_ff  <= WORK_W'(req_base_second) + WORK_W'(req_delta_seconds);
         mi_ff  <= WORK_W'(req_base_minute) + WORK_W'(req_delta_minutes);
         hr_ff  <= WORK_W'(req_base_hour) + WORK_W'(req_delta_hours);
         dy_ff  <= WORK_W'(req_base_day) + WORK_W'(req_delta_days);
      end
      if (cmd.div_apply) begin
         case (cmd.op)
            OP_NS: begin
               ns_ff <= $signed(WORK_W'(div_rmd));
               sc_ff <= sc_ff + div_quot;
            end
            OP_SEC: begin
               sc_ff <= $signed(WORK_W'(div_rmd));
               mi_ff <= mi_ff + div_quot;
            end
            OP_MIN: begin
               mi_ff <= $signed(WORK_W'(div_rmd));
               hr_ff <= hr_ff + div_quot;
            end
            OP_HOUR: begin
               hr_ff <= $signed(WORK_W'(div_rmd));
               dy_ff <= dy_ff + div_quot;
            end
            OP_Y400: begin
               era_ff <= div_quot;
               doe_ff <= doe_calc;
            end
            OP_ERA: begin
               era2_ff <= div_quot;
               doe2_ff <= div_rmd[17:0];
            end
            OP_D1460: begin
               t_ff <= doe2_ff - div_quot[17:0] + 18'(cent_days_of(doe2_ff))
                     - ((doe2_ff == 18'd146096) ? 18'd1 : 18'd0);
            end
            OP_D365: begin
               yoe2_ff <= div_quot[8:0];
            end
            default: begin
               ns_ff <= ns_ff;
            end
         endcase
      end
      if (cmd.calc_doy) begin
         doy_ff <= 9'(doe2_ff - (18'(yoe2_ff) * 18'd365 + 18'(yoe2_ff >> 2)
                   - 18'(cent_of(yoe2_ff))));
      end
      if (cmd.finish) begin
         if (bad_ff || y_out < -WORK_W'(32768) || y_out > WORK_W'(32767)) begin
            status_ff <= bad_ff ? STATUS_BAD_MONTH : STATUS_YEAR_OVF;
            year_ff   <= '0;
            month_ff  <= '0;
            day_ff    <= '0;
            hour_ff   <= '0;
            minute_ff <= '0;
            second_ff <= '0;
            nano_ff   <= '0;
         end else begin
            status_ff <= STATUS_OK;
            year_ff   <= y_out[15:0];
            month_ff  <= m_out;
            day_ff    <= d_out;
            hour_ff   <= hr_ff[4:0];
            minute_ff <= mi_ff[5:0];
            second_ff <= sc_ff[5:0];
            nano_ff   <= ns_ff[29:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.bad_month   = bad_ff;
   assign stat.div_done    = div_done;
   assign stat.out_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_year       = year_ff;
   assign rsp_out_month      = month_ff;
   assign rsp_out_day        = day_ff;
   assign rsp_out_hour       = hour_ff;
   assign rsp_out_minute     = minute_ff;
   assign rsp_out_second     = second_ff;
   assign rsp_out_nanosecond = nano_ff;
   assign rsp_status         = status_ff;

endmodule

// File: rtl/dtan_ctrl.sv
// dtan_ctrl: sequencer that steps the datapath through carries and calendar steps
// depends on dtan_pkg
module dtan_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dtan_pkg::stat_type  stat,
   output dtan_pkg::cmd_type   cmd
);
   import dtan_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_START  = 6'b000100,
      ST_WAIT   = 6'b001000,
      ST_DOY    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_apply = 1'b0;
      cmd.calc_doy  = 1'b0;
      cmd.finish    = 1'b0;
      cmd.op        = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            op_in    = OP_NS;
            state_in = stat.bad_month ? ST_FINISH : ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.div_done) begin
               cmd.div_apply = 1'b1;
               if (op_ff == OP_D365) begin
                  state_in = ST_DOY;
               end else begin
                  op_in    = op_type'(3'(op_ff) + 3'd1);
                  state_in = ST_START;
               end
            end
         end
         ST_DOY: begin
            cmd.calc_doy = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (!stat.out_blocked) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_NS;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/datetime_add_and_normalize_unit.sv
// datetime_add_and_normalize_unit: top level, adds signed offsets to a date-time
// and normalizes it on the gregorian calendar; depends on dtan_pkg, dtan_ctrl, dtan_dp
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | base date-time fields and five deltas
//   rsp_    | out       | rsp_valid/rsp_stall  | normalized date-time and status
//
// one item at a time, each through the shared constant divider:
// eight divisions, each four partial products of a reciprocal multiply, a quotient,
// a remainder and a correction step plus the sequencer's start step and the done flag,
// and the load, month check, day-of-year and finish steps
// an invalid month skips the arithmetic and goes from the month check to finish
// reset is synchronous and clears the sequencer and the result valid flag
// a new item is taken while a finished result waits on rsp_stall; the next
// result then waits in its last step until the output register frees up
module datetime_add_and_normalize_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_base_year,
   input  logic signed [7:0]  req_base_month,
   input  logic signed [31:0] req_base_day,
   input  logic signed [31:0] req_base_hour,
   input  logic signed [31:0] req_base_minute,
   input  logic signed [31:0] req_base_second,
   input  logic signed [31:0] req_base_nanosecond,
   input  logic signed [31:0] req_delta_days,
   input  logic signed [31:0] req_delta_hours,
   input  logic signed [31:0] req_delta_minutes,
   input  logic signed [31:0] req_delta_seconds,
   input  logic signed [31:0] req_delta_nanos,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_year,
   output logic [3:0]         rsp_out_month,
   output logic [4:0]         rsp_out_day,
   output logic [4:0]         rsp_out_hour,
   output logic [5:0]         rsp_out_minute,
   output logic [5:0]         rsp_out_second,
   output logic [29:0]        rsp_out_nanosecond,
   output logic [1:0]         rsp_status
);
   import dtan_pkg::*;

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: load, month check, the eight divisions, day-of-year, finish
   dtan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: carry chain, day number, civil date and the result register
   dtan_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_base_year       (req_base_year),
      .req_base_month      (req_base_month),
      .req_base_day        (req_base_day),
      .req_base_hour       (req_base_hour),
      .req_base_minute     (req_base_minute),
      .req_base_second     (req_base_second),
      .req_base_nanosecond (req_base_nanosecond),
      .req_delta_days      (req_delta_days),
      .req_delta_hours     (req_delta_hours),
      .req_delta_minutes   (req_delta_minutes),
      .req_delta_seconds   (req_delta_seconds),
      .req_delta_nanos     (req_delta_nanos),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_out_year        (rsp_out_year),
      .rsp_out_month       (rsp_out_month),
      .rsp_out_day         (rsp_out_day),
      .rsp_out_hour        (rsp_out_hour),
      .rsp_out_minute      (rsp_out_minute),
      .rsp_out_second      (rsp_out_second),
      .rsp_out_nanosecond  (rsp_out_nanosecond),
      .rsp_status          (rsp_status)
   );

endmodule
